>>> rtl/gcl_pkg.sv
// Package for the glyph cache allocator: item kinds, result status codes,
// port field widths, parameter defaults and the memory command structs.
// No dependencies.
package gcl_pkg;

	// Parameter defaults
	localparam int unsigned POOL_BYTES_DEF  = 262144;
	localparam int unsigned ENTRY_COUNT_DEF = 64;

	// Port field widths
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned PX_W     = 8;
	localparam int unsigned DIM_W    = 10;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned OFFSET_W = 18;
	localparam int unsigned BYTES_W  = 19;
	localparam int unsigned STAT_W   = 32;
	localparam int unsigned TOTAL_W  = 7;

	// Width of the rounded request size (product of two 10-bit dims, plus round-up)
	localparam int unsigned NEED_W = 21;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EPOCH  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STATS  = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INSERT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd6;
	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd7;

	// Entry table commands
	typedef struct packed {
		logic wr;
		logic set_valid;
		logic clr_valid;
		logic clr_all;
	} ent_cmd_t;

	// Free list commands
	typedef struct packed {
		logic wr;
		logic cnt_init;
		logic cnt_inc;
		logic cnt_dec;
	} fl_cmd_t;

endpackage

>>> rtl/gcl_if.sv
// Request and result channel interfaces of the glyph cache allocator.
// Depends on gcl_pkg for the field widths.
interface gcl_req_if;
	import gcl_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [CP_W-1:0]     code_point;
	logic [PX_W-1:0]     pixel_size;
	logic [DIM_W-1:0]    glyph_width;
	logic [DIM_W-1:0]    glyph_height;

	modport source (output valid, kind, code_point, pixel_size, glyph_width, glyph_height,
		input ready);
	modport sink (input valid, kind, code_point, pixel_size, glyph_width, glyph_height,
		output ready);
endinterface

interface gcl_rsp_if;
	import gcl_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OFFSET_W-1:0] pool_offset;
	logic [DIM_W-1:0]    width_out;
	logic [DIM_W-1:0]    height_out;
	logic [BYTES_W-1:0]  byte_count;
	logic [STAT_W-1:0]   hits_total;
	logic [STAT_W-1:0]   misses_total;
	logic [STAT_W-1:0]   evictions_total;
	logic [BYTES_W-1:0]  held_bytes;
	logic [TOTAL_W-1:0]  entry_total;

	modport source (output valid, status, pool_offset, width_out, height_out, byte_count,
		hits_total, misses_total, evictions_total, held_bytes, entry_total, input ready);
	modport sink (input valid, status, pool_offset, width_out, height_out, byte_count,
		hits_total, misses_total, evictions_total, held_bytes, entry_total, output ready);
endinterface

>>> rtl/gcl_entry_table.sv
// Glyph entry table: one synchronous memory of entry words plus valid flags
// and a lowest-free-slot encoder. Depends on gcl_pkg.
module gcl_entry_table #(
	parameter int unsigned ENTRY_COUNT = 64,
	parameter int unsigned WORD_W      = 160,
	parameter int unsigned IDX_W       = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gcl_pkg::ent_cmd_t     cmd,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [WORD_W-1:0]     rd_data,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [WORD_W-1:0]     wr_data,
	input  logic [IDX_W-1:0]      clr_addr,
	output logic [ENTRY_COUNT-1:0] valid,
	output logic [IDX_W-1:0]      free_idx,
	output logic                  full
);
	import gcl_pkg::*;

	logic [WORD_W-1:0]      mem [ENTRY_COUNT];
	logic [WORD_W-1:0]      rd_q;
	logic [ENTRY_COUNT-1:0] valid_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clr_all) begin
			valid_q <= '0;
		end else begin
			if (cmd.clr_valid) begin
				valid_q[clr_addr] <= 1'b0;
			end
			if (cmd.wr && cmd.set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Lowest invalid slot
	always_comb begin
		free_idx = '0;
		for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign full    = &valid_q;
	assign valid   = valid_q;
	assign rd_data = rd_q;

endmodule

>>> rtl/gcl_free_list.sv
// Address-sorted free block list: one synchronous memory of {offset, size}
// words and the block count register. Depends on gcl_pkg.
module gcl_free_list #(
	parameter int unsigned DEPTH  = 65,
	parameter int unsigned WORD_W = 37,
	parameter int unsigned ADDR_W = 7,
	parameter int unsigned CNT_W  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcl_pkg::fl_cmd_t   cmd,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [WORD_W-1:0]  rd_data,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0]  wr_data,
	output logic [CNT_W-1:0]   count
);
	import gcl_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [CNT_W-1:0]  count_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Block count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (cmd.cnt_init) begin
			count_q <= CNT_W'(1);
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign rd_data = rd_q;
	assign count   = count_q;

endmodule

>>> rtl/glyph_cache_lru_epoch_allocator.sv
// Glyph cache allocator. Each item is handled alone by a sequencer that walks the
// entry table and the free list one word at a time (a read state, then a check
// or write state). A lookup walks the entry table until a hit or its end; an insert
// adds a free list walk, and each eviction a victim scan of the entry table plus
// a release walk and shift of the free list. After reset the block seeds the free
// list in its init state before it takes the first item. A new item is taken as
// soon as the previous one is finished, while its result may still wait in the
// output register.
module glyph_cache_lru_epoch_allocator #(
	parameter int unsigned POOL_BYTES  = gcl_pkg::POOL_BYTES_DEF,
	parameter int unsigned ENTRY_COUNT = gcl_pkg::ENTRY_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gcl_req_if.sink   req,
	gcl_rsp_if.source rsp
);
	import gcl_pkg::*;

	localparam int unsigned OFF_W  = $clog2(POOL_BYTES);
	localparam int unsigned SZ_W   = $clog2(POOL_BYTES + 1);
	localparam int unsigned CMP_W  = (SZ_W > NEED_W) ? SZ_W : NEED_W;
	localparam int unsigned SUM_W  = SZ_W + 1;
	localparam int unsigned IDX_W  = $clog2(ENTRY_COUNT);
	localparam int unsigned CNT_W  = $clog2(ENTRY_COUNT + 1);
	localparam int unsigned FL_DEPTH = ENTRY_COUNT + 1;
	localparam int unsigned FA_W   = $clog2(FL_DEPTH);
	localparam int unsigned FP_W   = $clog2(FL_DEPTH + 1);

	typedef struct packed {
		logic [CP_W-1:0]   cp;
		logic [PX_W-1:0]   px;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [OFF_W-1:0]  off;
		logic [SZ_W-1:0]   nb;
		logic [31:0]       stamp;
		logic [31:0]       epoch;
	} ent_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [SZ_W-1:0]  size;
	} blk_t;

	// Sequencer states
	localparam logic [4:0] S_INIT    = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_CLEAR   = 5'd2;
	localparam logic [4:0] S_KEY_RD  = 5'd3;
	localparam logic [4:0] S_KEY_CHK = 5'd4;
	localparam logic [4:0] S_FIT_RD  = 5'd5;
	localparam logic [4:0] S_FIT_CHK = 5'd6;
	localparam logic [4:0] S_VIC_RD  = 5'd7;
	localparam logic [4:0] S_VIC_CHK = 5'd8;
	localparam logic [4:0] S_EVICT   = 5'd9;
	localparam logic [4:0] S_REL_RD  = 5'd10;
	localparam logic [4:0] S_REL_CHK = 5'd11;
	localparam logic [4:0] S_REL_DEC = 5'd12;
	localparam logic [4:0] S_INS_RD  = 5'd13;
	localparam logic [4:0] S_INS_WR  = 5'd14;
	localparam logic [4:0] S_RM_RD   = 5'd15;
	localparam logic [4:0] S_RM_WR   = 5'd16;
	localparam logic [4:0] S_ALLOC   = 5'd17;
	localparam logic [4:0] S_FULL    = 5'd18;
	localparam logic [4:0] S_DONE    = 5'd19;

	logic [4:0] state_q, rel_ret_q, rm_ret_q;

	// Item registers
	logic [KIND_W-1:0] kind_q;
	logic [CP_W-1:0]   cp_q;
	logic [PX_W-1:0]   px_q;
	logic [DIM_W-1:0]  w_q, h_q;
	logic [CMP_W-1:0]  need_q;

	// Walk pointers and scratch
	logic [IDX_W-1:0] ptr_q, vic_q;
	logic [FP_W-1:0]  fptr_q, sptr_q, rptr_q;
	logic             vfound_q, have_cur_q;
	logic [31:0]      worst_q;
	logic [OFF_W-1:0] vic_off_q, got_q, rel_off_q;
	logic [SZ_W-1:0]  vic_nb_q, rel_size_q;
	blk_t             prev_q, cur_q;

	// Global state
	logic [31:0]      stamp_q, epoch_q, hit_q, miss_q, evict_q;
	logic [SZ_W-1:0]  used_q;
	logic [CNT_W-1:0] nval_q;

	// Result under construction and output register
	logic [STATUS_W-1:0] res_status_q;
	logic [OFF_W-1:0]    res_off_q;
	logic [DIM_W-1:0]    res_w_q, res_h_q;
	logic [SZ_W-1:0]     res_nb_q;
	logic                out_valid_q;
	logic                out_load;
	logic [STATUS_W-1:0] o_status_q;
	logic [OFFSET_W-1:0] o_off_q;
	logic [DIM_W-1:0]    o_w_q, o_h_q;
	logic [BYTES_W-1:0]  o_nb_q, o_used_q;
	logic [STAT_W-1:0]   o_hit_q, o_miss_q, o_evict_q;
	logic [TOTAL_W-1:0]  o_total_q;

	// Memory ports
	ent_cmd_t             ent_cmd;
	logic [IDX_W-1:0]     ent_wr_addr;
	ent_t                 ent_wr_data, ent_q;
	logic [$bits(ent_t)-1:0] ent_rd_raw;
	logic [ENTRY_COUNT-1:0]  ent_valid;
	logic [IDX_W-1:0]     ent_free;
	logic                 ent_full;
	fl_cmd_t              fl_cmd;
	logic [FA_W-1:0]      fl_rd_addr, fl_wr_addr;
	blk_t                 fl_wr_data, fl_q;
	logic [$bits(blk_t)-1:0] fl_rd_raw;
	logic [FP_W-1:0]      fl_cnt;

	gcl_entry_table #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.WORD_W      ($bits(ent_t)),
		.IDX_W       (IDX_W)
	) u_entry (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ent_cmd),
		.rd_addr  (ptr_q),
		.rd_data  (ent_rd_raw),
		.wr_addr  (ent_wr_addr),
		.wr_data  (ent_wr_data),
		.clr_addr (vic_q),
		.valid    (ent_valid),
		.free_idx (ent_free),
		.full     (ent_full)
	);

	gcl_free_list #(
		.DEPTH  (FL_DEPTH),
		.WORD_W ($bits(blk_t)),
		.ADDR_W (FA_W),
		.CNT_W  (FP_W)
	) u_free (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (fl_cmd),
		.rd_addr (fl_rd_addr),
		.rd_data (fl_rd_raw),
		.wr_addr (fl_wr_addr),
		.wr_data (fl_wr_data),
		.count   (fl_cnt)
	);

	assign ent_q = ent_t'(ent_rd_raw);
	assign fl_q  = blk_t'(fl_rd_raw);

	// Request size rounded up to four bytes
	logic [CMP_W-1:0] prod_in, need_in;
	assign prod_in = CMP_W'(req.glyph_width) * CMP_W'(req.glyph_height);
	assign need_in = (prod_in + CMP_W'(3)) & ~CMP_W'(3);

	// Decisions on the word just read
	logic key_hit, fits, vic_take, join_prev, join_next, ptr_last, fit_end, rel_end;
	logic ins_here, rm_end;
	logic [FP_W-1:0] fptr_m1, sptr_m1, rptr_p1;

	assign ptr_last = (ptr_q == IDX_W'(ENTRY_COUNT - 1));
	assign key_hit  = ent_valid[ptr_q] && (ent_q.cp == cp_q) && (ent_q.px == px_q);
	assign fits     = CMP_W'(fl_q.size) >= need_q;
	assign vic_take = ent_valid[ptr_q] && (ent_q.epoch != epoch_q) &&
		(!vfound_q || (ent_q.stamp < worst_q));
	assign fit_end  = (fptr_q == fl_cnt);
	assign rel_end  = (fptr_q == fl_cnt);
	assign join_prev = (fptr_q != '0) &&
		((SUM_W'(prev_q.off) + SUM_W'(prev_q.size)) == SUM_W'(rel_off_q));
	assign join_next = have_cur_q &&
		((SUM_W'(rel_off_q) + SUM_W'(rel_size_q)) == SUM_W'(cur_q.off));
	assign fptr_m1  = fptr_q - FP_W'(1);
	assign sptr_m1  = sptr_q - FP_W'(1);
	assign rptr_p1  = rptr_q + FP_W'(1);
	assign ins_here = (sptr_q == fptr_q);
	assign rm_end   = (rptr_p1 >= fl_cnt);

	// Load the output register when the result is ready and the register is free
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Memory control
	always_comb begin
		ent_cmd     = '0;
		ent_wr_addr = ptr_q;
		ent_wr_data = ent_q;
		fl_cmd      = '0;
		fl_rd_addr  = fptr_q[FA_W-1:0];
		fl_wr_addr  = fptr_q[FA_W-1:0];
		fl_wr_data  = fl_q;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				fl_cmd.wr       = 1'b1;
				fl_cmd.cnt_init = 1'b1;
				fl_wr_addr      = '0;
				fl_wr_data.off  = '0;
				fl_wr_data.size = SZ_W'(POOL_BYTES);
				ent_cmd.clr_all = (state_q == S_CLEAR);
			end
			S_KEY_CHK: begin
				// promote on hit
				ent_cmd.wr        = key_hit;
				ent_wr_data.epoch = epoch_q;
				ent_wr_data.stamp = stamp_q + 32'd1;
			end
			S_FIT_CHK: begin
				// split the block when larger than the request
				fl_cmd.wr       = fits && (CMP_W'(fl_q.size) != need_q);
				fl_wr_data.off  = OFF_W'(CMP_W'(fl_q.off) + need_q);
				fl_wr_data.size = SZ_W'(CMP_W'(fl_q.size) - need_q);
			end
			S_EVICT: begin
				ent_cmd.clr_valid = 1'b1;
			end
			S_REL_DEC: begin
				if (join_prev) begin
					fl_cmd.wr       = 1'b1;
					fl_wr_addr      = fptr_m1[FA_W-1:0];
					fl_wr_data.off  = prev_q.off;
					fl_wr_data.size = join_next ?
						SZ_W'(prev_q.size + rel_size_q + cur_q.size) :
						SZ_W'(prev_q.size + rel_size_q);
				end else if (join_next) begin
					fl_cmd.wr       = 1'b1;
					fl_wr_data.off  = rel_off_q;
					fl_wr_data.size = SZ_W'(cur_q.size + rel_size_q);
				end
			end
			S_INS_RD: begin
				fl_rd_addr = sptr_m1[FA_W-1:0];
				if (ins_here) begin
					fl_cmd.wr       = 1'b1;
					fl_cmd.cnt_inc  = 1'b1;
					fl_wr_data.off  = rel_off_q;
					fl_wr_data.size = rel_size_q;
				end
			end
			S_INS_WR: begin
				fl_cmd.wr  = 1'b1;
				fl_wr_addr = sptr_q[FA_W-1:0];
			end
			S_RM_RD: begin
				fl_rd_addr     = rptr_p1[FA_W-1:0];
				fl_cmd.cnt_dec = rm_end;
			end
			S_RM_WR: begin
				fl_cmd.wr  = 1'b1;
				fl_wr_addr = rptr_q[FA_W-1:0];
			end
			S_ALLOC: begin
				ent_cmd.wr        = !ent_full;
				ent_cmd.set_valid = 1'b1;
				ent_wr_addr       = ent_free;
				ent_wr_data.cp    = cp_q;
				ent_wr_data.px    = px_q;
				ent_wr_data.w     = w_q;
				ent_wr_data.h     = h_q;
				ent_wr_data.off   = got_q;
				ent_wr_data.nb    = SZ_W'(need_q);
				ent_wr_data.stamp = stamp_q + 32'd1;
				ent_wr_data.epoch = epoch_q;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// Output register valid: set on load, drop once the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rel_ret_q   <= S_ALLOC;
			rm_ret_q    <= S_ALLOC;
			stamp_q     <= '0;
			epoch_q     <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
			used_q      <= '0;
			nval_q      <= '0;
			vfound_q    <= 1'b0;
			have_cur_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q       <= req.kind;
						cp_q         <= req.code_point;
						px_q         <= req.pixel_size;
						w_q          <= req.glyph_width;
						h_q          <= req.glyph_height;
						need_q       <= need_in;
						ptr_q        <= '0;
						res_status_q <= ST_DONE;
						res_off_q    <= '0;
						res_w_q      <= '0;
						res_h_q      <= '0;
						res_nb_q     <= '0;
						unique case (req.kind)
							KIND_LOOKUP, KIND_INSERT: state_q <= S_KEY_RD;
							KIND_EPOCH: begin
								epoch_q <= epoch_q + 32'd1;
								state_q <= S_DONE;
							end
							KIND_CLEAR: state_q <= S_CLEAR;
							KIND_STATS: begin
								hit_q   <= '0;
								miss_q  <= '0;
								evict_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					stamp_q <= '0;
					used_q  <= '0;
					nval_q  <= '0;
					state_q <= S_DONE;
				end
				S_KEY_RD: begin
					state_q <= S_KEY_CHK;
				end
				S_KEY_CHK: begin
					if (key_hit) begin
						stamp_q   <= stamp_q + 32'd1;
						res_off_q <= ent_q.off;
						res_w_q   <= ent_q.w;
						res_h_q   <= ent_q.h;
						res_nb_q  <= ent_q.nb;
						if (kind_q == KIND_LOOKUP) begin
							hit_q        <= hit_q + 32'd1;
							res_status_q <= ST_HIT;
						end else begin
							res_status_q <= ST_PRESENT;
						end
						state_q <= S_DONE;
					end else if (ptr_last) begin
						if (kind_q == KIND_LOOKUP) begin
							miss_q       <= miss_q + 32'd1;
							res_status_q <= ST_MISS;
							state_q      <= S_DONE;
						end else if (need_q == '0) begin
							res_status_q <= ST_ZERO;
							state_q      <= S_DONE;
						end else begin
							fptr_q  <= '0;
							state_q <= S_FIT_RD;
						end
					end else begin
						ptr_q   <= ptr_q + IDX_W'(1);
						state_q <= S_KEY_RD;
					end
				end
				S_FIT_RD: begin
					if (fit_end) begin
						// nothing fits: look for the oldest entry outside this epoch
						ptr_q    <= '0;
						vfound_q <= 1'b0;
						state_q  <= S_VIC_RD;
					end else begin
						state_q <= S_FIT_CHK;
					end
				end
				S_FIT_CHK: begin
					if (fits) begin
						got_q <= fl_q.off;
						if (CMP_W'(fl_q.size) != need_q) begin
							state_q <= S_ALLOC;
						end else begin
							rptr_q   <= fptr_q;
							rm_ret_q <= S_ALLOC;
							state_q  <= S_RM_RD;
						end
					end else begin
						fptr_q  <= fptr_q + FP_W'(1);
						state_q <= S_FIT_RD;
					end
				end
				S_VIC_RD: begin
					state_q <= S_VIC_CHK;
				end
				S_VIC_CHK: begin
					if (vic_take) begin
						vfound_q  <= 1'b1;
						worst_q   <= ent_q.stamp;
						vic_q     <= ptr_q;
						vic_off_q <= ent_q.off;
						vic_nb_q  <= ent_q.nb;
					end
					if (ptr_last) begin
						if (vfound_q || vic_take) begin
							state_q <= S_EVICT;
						end else begin
							res_status_q <= ST_NOSPACE;
							state_q      <= S_DONE;
						end
					end else begin
						ptr_q   <= ptr_q + IDX_W'(1);
						state_q <= S_VIC_RD;
					end
				end
				S_EVICT: begin
					evict_q    <= evict_q + 32'd1;
					used_q     <= used_q - vic_nb_q;
					nval_q     <= nval_q - CNT_W'(1);
					rel_off_q  <= vic_off_q;
					rel_size_q <= vic_nb_q;
					rel_ret_q  <= S_FIT_RD;
					fptr_q     <= '0;
					have_cur_q <= 1'b0;
					state_q    <= S_REL_RD;
				end
				S_REL_RD: begin
					if (rel_end) begin
						have_cur_q <= 1'b0;
						state_q    <= S_REL_DEC;
					end else begin
						state_q <= S_REL_CHK;
					end
				end
				S_REL_CHK: begin
					if (fl_q.off > rel_off_q) begin
						cur_q      <= fl_q;
						have_cur_q <= 1'b1;
						state_q    <= S_REL_DEC;
					end else begin
						prev_q  <= fl_q;
						fptr_q  <= fptr_q + FP_W'(1);
						state_q <= S_REL_RD;
					end
				end
				S_REL_DEC: begin
					if (join_prev && join_next) begin
						rptr_q   <= fptr_q;
						rm_ret_q <= rel_ret_q;
						state_q  <= S_RM_RD;
					end else if (join_prev || join_next) begin
						fptr_q  <= '0;
						state_q <= rel_ret_q;
					end else if (fl_cnt < FP_W'(FL_DEPTH)) begin
						// open a slot at the insert position
						sptr_q  <= fl_cnt;
						state_q <= S_INS_RD;
					end else begin
						fptr_q  <= '0;
						state_q <= rel_ret_q;
					end
				end
				S_INS_RD: begin
					if (ins_here) begin
						fptr_q  <= '0;
						state_q <= rel_ret_q;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					sptr_q  <= sptr_m1;
					state_q <= S_INS_RD;
				end
				S_RM_RD: begin
					if (rm_end) begin
						fptr_q  <= '0;
						state_q <= rm_ret_q;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					rptr_q  <= rptr_p1;
					state_q <= S_RM_RD;
				end
				S_ALLOC: begin
					if (ent_full) begin
						// no slot: hand the block back
						rel_off_q  <= got_q;
						rel_size_q <= SZ_W'(need_q);
						rel_ret_q  <= S_FULL;
						fptr_q     <= '0;
						have_cur_q <= 1'b0;
						state_q    <= S_REL_RD;
					end else begin
						stamp_q      <= stamp_q + 32'd1;
						used_q       <= used_q + SZ_W'(need_q);
						nval_q       <= nval_q + CNT_W'(1);
						res_status_q <= ST_INSERT;
						res_off_q    <= got_q;
						res_w_q      <= w_q;
						res_h_q      <= h_q;
						res_nb_q     <= SZ_W'(need_q);
						state_q      <= S_DONE;
					end
				end
				S_FULL: begin
					res_status_q <= ST_FULL;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hand over the result once the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_status_q <= res_status_q;
			o_off_q    <= OFFSET_W'(res_off_q);
			o_w_q      <= res_w_q;
			o_h_q      <= res_h_q;
			o_nb_q     <= BYTES_W'(res_nb_q);
			o_hit_q    <= hit_q;
			o_miss_q   <= miss_q;
			o_evict_q  <= evict_q;
			o_used_q   <= BYTES_W'(used_q);
			o_total_q  <= TOTAL_W'(nval_q);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = o_status_q;
	assign rsp.pool_offset     = o_off_q;
	assign rsp.width_out       = o_w_q;
	assign rsp.height_out      = o_h_q;
	assign rsp.byte_count      = o_nb_q;
	assign rsp.hits_total      = o_hit_q;
	assign rsp.misses_total    = o_miss_q;
	assign rsp.evictions_total = o_evict_q;
	assign rsp.held_bytes      = o_used_q;
	assign rsp.entry_total     = o_total_q;

	// Entry count tracks the valid flags
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(ent_valid) == 32'(nval_q))
		else $error("entry count out of step with valid flags");

	// Held bytes never exceed the pool
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(POOL_BYTES))
		else $error("used bytes exceed pool");

	// Free list never outgrows its memory
	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fl_cnt) <= 32'(FL_DEPTH))
		else $error("free list overflow");

	// A result is only loaded when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !rsp.ready) |=> out_valid_q)
		else $error("pending result lost");

endmodule

>>> tb/gcl_tb_pkg.sv
// Scoreboard class for the glyph cache allocator bench: a predictor of the
// entry table, free list and counters, plus the queue of expected results.
// Depends on gcl_pkg.
package gcl_tb_pkg;
	import gcl_pkg::*;

	localparam int unsigned POOL   = POOL_BYTES_DEF;
	localparam int unsigned ENTRIES = ENTRY_COUNT_DEF;
	localparam int unsigned FDEPTH = ENTRIES + 1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] pool_offset;
		logic [DIM_W-1:0]    width_out;
		logic [DIM_W-1:0]    height_out;
		logic [BYTES_W-1:0]  byte_count;
		logic [STAT_W-1:0]   hits_total;
		logic [STAT_W-1:0]   misses_total;
		logic [STAT_W-1:0]   evictions_total;
		logic [BYTES_W-1:0]  held_bytes;
		logic [TOTAL_W-1:0]  entry_total;
	} glyph_rsp_t;

	class glyph_cache_scoreboard;
		bit              valid_q[ENTRIES];
		bit [CP_W-1:0]   cp_q[ENTRIES];
		bit [PX_W-1:0]   px_q[ENTRIES];
		bit [DIM_W-1:0]  w_q[ENTRIES];
		bit [DIM_W-1:0]  h_q[ENTRIES];
		bit [31:0]       off_q[ENTRIES];
		bit [31:0]       bytes_q[ENTRIES];
		bit [31:0]       stamp_q[ENTRIES];
		bit [31:0]       epoch_q[ENTRIES];
		bit [31:0]       free_off[FDEPTH];
		bit [31:0]       free_size[FDEPTH];
		int unsigned     free_cnt;
		bit [31:0]       stamp_ctr, epoch_ctr, hits, misses, evicts;
		glyph_rsp_t      pending[$];
		int unsigned     errors, matched;
		int unsigned     status_seen[8];

		function new();
			epoch_ctr = 0; stamp_ctr = 0; hits = 0; misses = 0; evicts = 0;
			errors = 0; matched = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (valid_q[i]) valid_q[i] = 0;
			foreach (free_off[i]) begin
				free_off[i] = 0;
				free_size[i] = 0;
			end
			free_size[0] = POOL;
			free_cnt = 1;
			stamp_ctr = 0;
		endfunction

		function void drop_block(int unsigned pos);
			for (int unsigned i = pos; i + 1 < free_cnt; i++) begin
				free_off[i] = free_off[i+1];
				free_size[i] = free_size[i+1];
			end
			free_cnt--;
		endfunction

		// return a block to the sorted list, merging with neighbors
		function void give_back(bit [31:0] off, bit [31:0] size);
			int unsigned pos;
			bit jp, jn;
			pos = free_cnt;
			for (int unsigned i = 0; i < free_cnt; i++)
				if (free_off[i] > off) begin
					pos = i;
					break;
				end
			jp = pos > 0 && free_off[pos-1] + free_size[pos-1] == off;
			jn = pos < free_cnt && off + size == free_off[pos];
			if (jp && jn) begin
				free_size[pos-1] += size + free_size[pos];
				drop_block(pos);
			end else if (jp) begin
				free_size[pos-1] += size;
			end else if (jn) begin
				free_off[pos] = off;
				free_size[pos] += size;
			end else if (free_cnt < FDEPTH) begin
				for (int unsigned i = free_cnt; i > pos; i--) begin
					free_off[i] = free_off[i-1];
					free_size[i] = free_size[i-1];
				end
				free_off[pos] = off;
				free_size[pos] = size;
				free_cnt++;
			end
		endfunction

		function int find_fit(bit [31:0] need);
			for (int i = 0; i < free_cnt; i++)
				if (free_size[i] >= need) return i;
			return -1;
		endfunction

		function int find_glyph(bit [CP_W-1:0] cp, bit [PX_W-1:0] px);
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i] && cp_q[i] == cp && px_q[i] == px) return i;
			return -1;
		endfunction

		function void touch(int i);
			epoch_q[i] = epoch_ctr;
			stamp_ctr += 1;
			stamp_q[i] = stamp_ctr;
		endfunction

		// predict the result of one accepted item
		function void note_request(bit [KIND_W-1:0] kind, bit [CP_W-1:0] cp,
				bit [PX_W-1:0] px, bit [DIM_W-1:0] w, bit [DIM_W-1:0] h);
			glyph_rsp_t r;
			bit [STATUS_W-1:0] st;
			bit [31:0] need, used, got, worst;
			int idx, blk, victim, n;
			st = ST_DONE; idx = -1; r = '0;
			case (kind)
				KIND_LOOKUP: begin
					idx = find_glyph(cp, px);
					if (idx < 0) begin
						misses += 1; st = ST_MISS;
					end else begin
						touch(idx); hits += 1; st = ST_HIT;
					end
				end
				KIND_INSERT: begin
					idx = find_glyph(cp, px);
					if (idx >= 0) begin
						touch(idx); st = ST_PRESENT;
					end else begin
						need = (32'(w) * 32'(h) + 3) & ~32'd3;
						if (need == 0) st = ST_ZERO;
						else begin
							st = ST_HIT;
							blk = find_fit(need);
							// evict the oldest entry outside the current epoch until a fit
							while (blk < 0) begin
								victim = -1; worst = 0;
								for (int i = 0; i < ENTRIES; i++) begin
									if (!valid_q[i] || epoch_q[i] == epoch_ctr) continue;
									if (victim < 0 || stamp_q[i] < worst) begin
										worst = stamp_q[i];
										victim = i;
									end
								end
								if (victim < 0) begin
									st = ST_NOSPACE;
									break;
								end
								give_back(off_q[victim], bytes_q[victim]);
								valid_q[victim] = 0;
								evicts += 1;
								blk = find_fit(need);
							end
							if (st != ST_NOSPACE) begin
								got = free_off[blk];
								if (free_size[blk] > need) begin
									free_off[blk] += need;
									free_size[blk] -= need;
								end else drop_block(blk);
								for (int i = 0; i < ENTRIES; i++)
									if (!valid_q[i]) begin
										idx = i;
										break;
									end
								if (idx < 0) begin
									give_back(got, need);
									st = ST_FULL;
								end else begin
									valid_q[idx] = 1; cp_q[idx] = cp; px_q[idx] = px;
									w_q[idx] = w; h_q[idx] = h;
									off_q[idx] = got; bytes_q[idx] = need;
									touch(idx);
									st = ST_INSERT;
								end
							end
						end
					end
				end
				KIND_EPOCH: epoch_ctr += 1;
				KIND_CLEAR: wipe();
				KIND_STATS: begin
					hits = 0; misses = 0; evicts = 0;
				end
				default: ;
			endcase
			r.status = st;
			if ((st == ST_HIT || st == ST_INSERT || st == ST_PRESENT) && idx >= 0) begin
				r.pool_offset = off_q[idx][OFFSET_W-1:0];
				r.width_out = w_q[idx];
				r.height_out = h_q[idx];
				r.byte_count = bytes_q[idx][BYTES_W-1:0];
			end
			used = 0; n = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i]) begin
					used += bytes_q[i];
					n++;
				end
			r.hits_total = hits;
			r.misses_total = misses;
			r.evictions_total = evicts;
			r.held_bytes = used[BYTES_W-1:0];
			r.entry_total = n[TOTAL_W-1:0];
			status_seen[st]++;
			pending.push_back(r);
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(glyph_rsp_t a);
			glyph_rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: status %0d", a.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a != e) errors++;
			else matched++;
			if (a.status != e.status)
				$error("status exp %0d got %0d", e.status, a.status);
			if (a.pool_offset != e.pool_offset)
				$error("pool_offset exp %0d got %0d", e.pool_offset, a.pool_offset);
			if (a.width_out != e.width_out)
				$error("width_out exp %0d got %0d", e.width_out, a.width_out);
			if (a.height_out != e.height_out)
				$error("height_out exp %0d got %0d", e.height_out, a.height_out);
			if (a.byte_count != e.byte_count)
				$error("byte_count exp %0d got %0d", e.byte_count, a.byte_count);
			if (a.hits_total != e.hits_total)
				$error("hits_total exp %0d got %0d", e.hits_total, a.hits_total);
			if (a.misses_total != e.misses_total)
				$error("misses_total exp %0d got %0d", e.misses_total, a.misses_total);
			if (a.evictions_total != e.evictions_total)
				$error("evictions_total exp %0d got %0d", e.evictions_total,
					a.evictions_total);
			if (a.held_bytes != e.held_bytes)
				$error("held_bytes exp %0d got %0d", e.held_bytes, a.held_bytes);
			if (a.entry_total != e.entry_total)
				$error("entry_total exp %0d got %0d", e.entry_total, a.entry_total);
		endfunction
	endclass
endpackage

>>> tb/tb.sv
// Top of the glyph cache allocator bench: clock, reset, request driver,
// result sink and end-of-run check. Depends on gcl_pkg, gcl_tb_pkg, the
// channel interfaces and the allocator RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gcl_pkg::*;
	import gcl_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 20000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit calm = 1'b0;
	int unsigned cycles = 0;
	bit [CP_W-1:0] key_cp[16];
	bit [PX_W-1:0] key_px[16];
	glyph_cache_scoreboard board;

	gcl_req_if req ();
	gcl_rsp_if rsp ();

	glyph_cache_lru_epoch_allocator dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	always #10 clk = ~clk;

	initial begin
		req.valid = 1'b0; req.kind = '0; req.code_point = '0;
		req.pixel_size = '0; req.glyph_width = '0; req.glyph_height = '0;
		rsp.ready = 1'b0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// accept results with random stall bursts, none in the last part
	initial begin : result_sink
		int stall;
		glyph_rsp_t a;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				a.status = rsp.status; a.pool_offset = rsp.pool_offset;
				a.width_out = rsp.width_out; a.height_out = rsp.height_out;
				a.byte_count = rsp.byte_count; a.hits_total = rsp.hits_total;
				a.misses_total = rsp.misses_total;
				a.evictions_total = rsp.evictions_total;
				a.held_bytes = rsp.held_bytes; a.entry_total = rsp.entry_total;
				board.check_result(a);
			end
			if (!calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 14);
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp.ready <= 1'b1;
			end else rsp.ready <= arst_n;
		end
	end

	// present one item and hold it until accepted
	task automatic send_item(bit [KIND_W-1:0] kind, bit [CP_W-1:0] cp,
			bit [PX_W-1:0] px, bit [DIM_W-1:0] w, bit [DIM_W-1:0] h);
		req.valid <= 1'b1; req.kind <= kind; req.code_point <= cp;
		req.pixel_size <= px; req.glyph_width <= w; req.glyph_height <= h;
		do @(posedge clk); while (!req.ready);
		board.note_request(kind, cp, px, w, h);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// mostly small glyphs, sometimes huge ones to force eviction
	task automatic random_item();
		int k, p;
		bit [DIM_W-1:0] w, h;
		k = $urandom_range(0, 15);
		p = $urandom_range(0, 15);
		if ($urandom_range(0, 9) == 0) begin
			w = DIM_W'($urandom); h = DIM_W'($urandom);
		end else if ($urandom_range(0, 5) == 0) begin
			w = DIM_W'($urandom_range(200, 1023)); h = DIM_W'($urandom_range(100, 400));
		end else begin
			w = DIM_W'($urandom_range(0, 40)); h = DIM_W'($urandom_range(0, 40));
		end
		case ($urandom_range(0, 99)) inside
			[0:39]: send_item(KIND_LOOKUP, key_cp[p], key_px[p], w, h);
			[40:49]: send_item(KIND_LOOKUP, CP_W'($urandom), PX_W'($urandom),
				DIM_W'($urandom), DIM_W'($urandom));
			[50:87]: send_item(KIND_INSERT, key_cp[k] ^ (21'($urandom_range(0, 3)) << 4),
				key_px[k], w, h);
			[88:93]: send_item(KIND_EPOCH, CP_W'($urandom), PX_W'($urandom), w, h);
			[94:95]: send_item(KIND_CLEAR, CP_W'($urandom), PX_W'($urandom), w, h);
			[96:97]: send_item(KIND_STATS, CP_W'($urandom), PX_W'($urandom), w, h);
			default: send_item(3'($urandom_range(5, 7)), CP_W'($urandom),
				PX_W'($urandom), w, h);
		endcase
	endtask

	initial begin : stimulus
		board = new();
		foreach (key_cp[i]) begin
			key_cp[i] = CP_W'($urandom_range(0, 1114111));
			key_px[i] = PX_W'($urandom);
		end
		key_cp[0] = 21'h10FFFF; key_px[0] = 8'hFF;
		key_cp[1] = '0; key_px[1] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind, special cases
		send_item(KIND_LOOKUP, key_cp[0], key_px[0], '0, '0);
		send_item(KIND_INSERT, key_cp[0], key_px[0], 10'd1023, 10'd1023);
		send_item(KIND_INSERT, key_cp[0], key_px[0], 10'd5, 10'd5);
		send_item(KIND_LOOKUP, key_cp[0], key_px[0], '0, '0);
		send_item(KIND_INSERT, key_cp[1], key_px[1], '0, 10'd7);
		send_item(KIND_INSERT, key_cp[1], key_px[1], 10'd1, 10'd3);
		send_item(KIND_INSERT, key_cp[2], key_px[2], 10'd1023, 10'd1023);
		send_item(KIND_EPOCH, '0, '0, '0, '0);
		send_item(KIND_INSERT, key_cp[2], key_px[2], 10'd1023, 10'd1023);
		send_item(KIND_INSERT, key_cp[3], key_px[3], 10'd1023, 10'd1023);
		send_item(KIND_LOOKUP, key_cp[1], key_px[1], '0, '0);
		send_item(KIND_STATS, '0, '0, '0, '0);
		send_item(3'd5, '0, '0, '0, '0);
		send_item(3'd7, 21'h1FFFFF, 8'hFF, 10'h3FF, 10'h3FF);
		send_item(KIND_CLEAR, '0, '0, '0, '0);
		// fill the table to hit table full
		for (int i = 0; i < ENTRIES + 2; i++)
			send_item(KIND_INSERT, 21'(i + 100), 8'd9, 10'd1, 10'd1);
		send_item(KIND_EPOCH, '0, '0, '0, '0);
		send_item(KIND_INSERT, 21'd5, 8'd1, 10'd1023, 10'd255);
		send_item(KIND_CLEAR, '0, '0, '0, '0);

		for (int n = 0; n < 1300; n++) begin
			if (n == 1150) calm = 1'b1;
			random_item();
		end
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("checked %0d results; hits %0d misses %0d inserts %0d no space %0d full %0d",
			board.matched, board.status_seen[ST_HIT], board.status_seen[ST_MISS],
			board.status_seen[ST_INSERT], board.status_seen[ST_NOSPACE],
			board.status_seen[ST_FULL]);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
